>>> hw/rtl/gsg_pkg.sv
// Shared types, constants and tables for the Gaussian/Sobel gradient unit.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package gsg_pkg;

   localparam int DEF_MAX_WIDTH = 1024;
   localparam int ROW_W         = 13;
   localparam int MAX_HEIGHT    = 4096;
   localparam int MIN_DIM       = 8;
   localparam int IN_ROWS       = 5;
   localparam int BLUR_ROWS     = 3;
   localparam int CSR_DATA_W    = 13;
   localparam logic [10:0] RESET_WIDTH  = 11'd512;
   localparam logic [12:0] RESET_HEIGHT = 13'd512;

   // Division by 159: multiply by ceil(2^24 / 159) and keep bits 31:24.
   // Exact for every sum the 5x5 kernel can produce.
   localparam logic [16:0] RECIP_159 = 17'd105518;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      DIR_0   = 2'd0,
      DIR_45  = 2'd1,
      DIR_90  = 2'd2,
      DIR_135 = 2'd3
   } dir_code_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_ACC,
      ST_DIV,
      ST_BLUR,
      ST_GRAD,
      ST_SQUARE,
      ST_PREP,
      ST_ROOT,
      ST_DONE
   } gsg_state_type;

   typedef struct packed {
      logic       load;
      logic       shift_in;
      logic       acc_en;
      logic       div;
      logic       blur;
      logic       grad;
      logic       square;
      logic       root_init;
      logic       root_step;
      logic       finish;
      logic [2:0] step;
   } gsg_cmd_type;

   typedef struct packed {
      logic out_active;
   } gsg_status_type;

   localparam logic [3:0] GAUSS_W [5][5] = '{
      '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2},
      '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
      '{4'd5, 4'd12, 4'd15, 4'd12, 4'd5},
      '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
      '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2}
   };

   // Reduces a value below ten modulo five.
   function automatic logic [2:0] wrap5(input logic [3:0] v);
      return (v >= 4'd5) ? 3'(v - 4'd5) : v[2:0];
   endfunction

   // Reduces a value below six modulo three.
   function automatic logic [1:0] wrap3(input logic [2:0] v);
      return (v >= 3'd3) ? 2'(v - 3'd3) : v[1:0];
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/gsg_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the line buffers; depends on nothing.
`default_nettype none

module gsg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> hw/rtl/gsg_ctrl.sv
// Sequencer for one item: fetch, blur accumulate, divide, gradient, root, hand-off.
// Uses gsg_pkg for the state, command and status types.
`default_nettype none

module gsg_ctrl import gsg_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output      logic           req_tready,
   output      logic           rsp_tvalid,
   input  wire logic           rsp_tready,
   output      gsg_cmd_type    cmd,
   input  wire gsg_status_type status
);

   gsg_state_type state_ff, state_in;
   logic [2:0]    step_ff, step_in;
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic          slot_free;

   assign slot_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_ACC;
            step_in  = 3'd0;
         end
         ST_ACC: begin
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd4) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV:    state_in = ST_BLUR;
         ST_BLUR:   state_in = ST_GRAD;
         ST_GRAD:   state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_PREP;
         ST_PREP: begin
            state_in = ST_ROOT;
            step_in  = 3'd0;
         end
         ST_ROOT: begin
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd7) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!status.out_active || slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.step      = step_ff;
      req_tready    = 1'b0;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_FETCH:  cmd.shift_in  = 1'b1;
         ST_ACC:    cmd.acc_en    = 1'b1;
         ST_DIV:    cmd.div       = 1'b1;
         ST_BLUR:   cmd.blur      = 1'b1;
         ST_GRAD:   cmd.grad      = 1'b1;
         ST_SQUARE: cmd.square    = 1'b1;
         ST_PREP:   cmd.root_init = 1'b1;
         ST_ROOT:   cmd.root_step = 1'b1;
         ST_DONE: begin
            if (!status.out_active) begin
               cmd.finish = 1'b1;
            end else if (slot_free) begin
               cmd.finish    = 1'b1;
               rsp_tvalid_in = 1'b1;
            end
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= 3'd0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;

endmodule

`default_nettype wire

>>> hw/rtl/gsg_dp.sv
// Datapath: frame counters, line buffers, blur and Sobel windows, divider and root.
// Uses gsg_pkg and instantiates gsg_ram for the line buffers.
`default_nettype none

module gsg_dp import gsg_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire gsg_cmd_type           cmd,
   output      gsg_status_type        status,
   input  wire logic                  mode,
   input  wire logic [7:0]            pixel,
   input  wire logic                  csr_we,
   input  wire logic [0:0]            csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output      logic [7:0]            blurred,
   output      logic [7:0]            magnitude,
   output      logic [1:0]            direction,
   output      logic                  last
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WID_W = $clog2(MAX_WIDTH + 1);

   // Configuration and effective frame size.
   logic [10:0]      frame_width_ff;
   logic [12:0]      frame_height_ff;
   logic [WID_W-1:0] w_eff, w_last;
   logic [ROW_W-1:0] h_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= RESET_WIDTH;
         frame_height_ff <= RESET_HEIGHT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[10:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[12:0];
            default:          frame_width_ff  <= frame_width_ff;
         endcase
      end
   end

   always_comb begin
      if (32'(frame_width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WID_W'(MAX_WIDTH);
      end else if (frame_width_ff < 11'(MIN_DIM)) begin
         w_eff = WID_W'(MIN_DIM);
      end else begin
         w_eff = WID_W'(frame_width_ff);
      end
      if (frame_height_ff > 13'(MAX_HEIGHT)) begin
         h_eff = ROW_W'(MAX_HEIGHT);
      end else if (frame_height_ff < 13'(MIN_DIM)) begin
         h_eff = ROW_W'(MIN_DIM);
      end else begin
         h_eff = frame_height_ff;
      end
      w_last = w_eff - WID_W'(1);
   end

   // Position counters: input item, blur item and output item.
   logic [COL_W-1:0] in_col_ff, in_col_in, b_col_ff, b_col_in, o_col_ff, o_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in, b_row_ff, b_row_in, o_row_ff, o_row_in;
   logic [2:0]       in_slot_ff, in_slot_in;
   logic [1:0]       b_slot_ff, b_slot_in;
   logic             blur_on_ff, blur_on_in, out_on_ff, out_on_in;
   logic             blur_active, out_active, out_last, blur_inside, out_inside;
   logic             in_col_end, b_col_end, o_col_end, restart;

   assign in_col_end  = (WID_W'(in_col_ff) == w_last);
   assign b_col_end   = (WID_W'(b_col_ff) == w_last);
   assign o_col_end   = (WID_W'(o_col_ff) == w_last);
   assign blur_active = blur_on_ff || (in_row_ff == ROW_W'(2) && in_col_ff == COL_W'(2));
   assign out_active  = out_on_ff || (in_row_ff == ROW_W'(3) && in_col_ff == COL_W'(3));
   assign out_last    = (o_row_ff == h_eff - ROW_W'(1)) && o_col_end;
   assign blur_inside = (b_row_ff >= ROW_W'(2)) && (b_row_ff < h_eff - ROW_W'(2))
                        && (WID_W'(b_col_ff) >= WID_W'(2))
                        && (WID_W'(b_col_ff) < w_eff - WID_W'(2));
   assign out_inside  = (o_row_ff >= ROW_W'(1)) && (o_row_ff < h_eff - ROW_W'(1))
                        && (o_col_ff != '0) && (WID_W'(o_col_ff) < w_last);
   assign restart     = csr_we || (cmd.finish && out_active && out_last);
   assign status.out_active = out_active;

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      in_slot_in = in_slot_ff;
      b_col_in   = b_col_ff;
      b_row_in   = b_row_ff;
      b_slot_in  = b_slot_ff;
      o_col_in   = o_col_ff;
      o_row_in   = o_row_ff;
      blur_on_in = blur_on_ff;
      out_on_in  = out_on_ff;
      if (restart) begin
         in_col_in  = '0;
         in_row_in  = '0;
         in_slot_in = '0;
         b_col_in   = '0;
         b_row_in   = '0;
         b_slot_in  = '0;
         o_col_in   = '0;
         o_row_in   = '0;
         blur_on_in = 1'b0;
         out_on_in  = 1'b0;
      end else if (cmd.finish) begin
         if (in_col_end) begin
            in_col_in  = '0;
            in_row_in  = in_row_ff + ROW_W'(1);
            in_slot_in = wrap5({1'b0, in_slot_ff} + 4'd1);
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
         if (blur_active) begin
            blur_on_in = 1'b1;
            if (b_col_end) begin
               b_col_in  = '0;
               b_row_in  = b_row_ff + ROW_W'(1);
               b_slot_in = wrap3({1'b0, b_slot_ff} + 3'd1);
            end else begin
               b_col_in = b_col_ff + COL_W'(1);
            end
         end
         if (out_active) begin
            out_on_in = 1'b1;
            if (o_col_end) begin
               o_col_in = '0;
               o_row_in = o_row_ff + ROW_W'(1);
            end else begin
               o_col_in = o_col_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         in_slot_ff <= '0;
         b_col_ff   <= '0;
         b_row_ff   <= '0;
         b_slot_ff  <= '0;
         o_col_ff   <= '0;
         o_row_ff   <= '0;
         blur_on_ff <= 1'b0;
         out_on_ff  <= 1'b0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         in_slot_ff <= in_slot_in;
         b_col_ff   <= b_col_in;
         b_row_ff   <= b_row_in;
         b_slot_ff  <= b_slot_in;
         o_col_ff   <= o_col_in;
         o_row_ff   <= o_row_in;
         blur_on_ff <= blur_on_in;
         out_on_ff  <= out_on_in;
      end
   end

   // Input line buffers: one memory per row slot, all read at the current column.
   logic       in_valid;
   logic [7:0] in_value, pix_ff;
   logic [7:0] in_rdata [IN_ROWS];

   assign in_valid = (in_row_ff < h_eff);
   assign in_value = (mode || !in_valid) ? 8'd0 : pixel;

   for (genvar s = 0; s < IN_ROWS; s++) begin : g_in_ram
      gsg_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_ram (
         .clock (clock),
         .we    (cmd.load && in_valid && in_slot_ff == 3'(s)),
         .waddr (in_col_ff),
         .wdata (in_value),
         .raddr (in_col_ff),
         .rdata (in_rdata[s])
      );
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pix_ff <= in_value;
      end
   end

   // 5x5 blur window, column 0 oldest, row 0 topmost.
   logic [7:0]  g_win_ff [5][5];
   logic [7:0]  g_win_in [5][5];
   logic [15:0] acc_ff, acc_in;
   logic [13:0] col_sum;
   logic [32:0] prod_ff;
   logic [7:0]  blur_val;

   always_comb begin
      g_win_in = g_win_ff;
      if (cmd.shift_in) begin
         for (int j = 0; j < 4; j++) begin
            g_win_in[j] = g_win_ff[j + 1];
         end
         // Rows four above to one above sit in the slots after the current one.
         for (int i = 0; i < 4; i++) begin
            g_win_in[4][i] = in_rdata[wrap5({1'b0, in_slot_ff} + 4'(i + 1))];
         end
         g_win_in[4][4] = pix_ff;
      end
   end

   always_comb begin
      col_sum = '0;
      for (int i = 0; i < 5; i++) begin
         col_sum = col_sum + 14'(g_win_ff[cmd.step][i]) * 14'(GAUSS_W[i][cmd.step]);
      end
      acc_in = cmd.shift_in ? 16'd0 : (cmd.acc_en ? acc_ff + 16'(col_sum) : acc_ff);
   end

   always_ff @(posedge clock) begin
      g_win_ff <= g_win_in;
      acc_ff   <= acc_in;
      if (cmd.div) begin
         prod_ff <= 33'(acc_ff) * 33'(RECIP_159);
      end
   end

   assign blur_val = blur_inside ? prod_ff[31:24] : 8'd0;

   // Blurred line buffers and the 3x3 Sobel window.
   logic [7:0] b_rdata [BLUR_ROWS];
   logic [7:0] s_win_ff [3][3];
   logic [7:0] s_win_in [3][3];

   for (genvar s = 0; s < BLUR_ROWS; s++) begin : g_blur_ram
      gsg_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_ram (
         .clock (clock),
         .we    (cmd.blur && blur_active && b_slot_ff == 2'(s)),
         .waddr (b_col_ff),
         .wdata (blur_val),
         .raddr (b_col_ff),
         .rdata (b_rdata[s])
      );
   end

   always_comb begin
      s_win_in = s_win_ff;
      if (cmd.blur && blur_active) begin
         s_win_in[0]    = s_win_ff[1];
         s_win_in[1]    = s_win_ff[2];
         s_win_in[2][0] = b_rdata[wrap3({1'b0, b_slot_ff} + 3'd1)];
         s_win_in[2][1] = b_rdata[wrap3({1'b0, b_slot_ff} + 3'd2)];
         s_win_in[2][2] = blur_val;
      end
   end

   always_ff @(posedge clock) begin
      s_win_ff <= s_win_in;
   end

   // Gradient, squares, direction and an 8-step integer square root.
   logic [10:0] gx_pos, gx_neg, gy_pos, gy_neg;
   logic [9:0]  a_ff, b_ff;
   logic        same_sign_ff, zero_x_ff;
   logic [19:0] a2_ff, b2_ff;
   logic [21:0] s_ff;
   logic [20:0] root_x;
   logic [16:0] rx_ff, root_ff, root_bit, root_try;
   logic        big_ff;
   logic [1:0]  dir_ff;

   assign gx_pos = 11'(s_win_ff[2][0]) + {2'b0, s_win_ff[2][1], 1'b0} + 11'(s_win_ff[2][2]);
   assign gx_neg = 11'(s_win_ff[0][0]) + {2'b0, s_win_ff[0][1], 1'b0} + 11'(s_win_ff[0][2]);
   assign gy_pos = 11'(s_win_ff[0][2]) + {2'b0, s_win_ff[1][2], 1'b0} + 11'(s_win_ff[2][2]);
   assign gy_neg = 11'(s_win_ff[0][0]) + {2'b0, s_win_ff[1][0], 1'b0} + 11'(s_win_ff[2][0]);

   assign root_x   = 21'(a2_ff) + 21'(b2_ff);
   assign root_bit = 17'(16'h4000 >> {cmd.step, 1'b0});
   assign root_try = rx_ff >= root_ff + root_bit ? root_ff + root_bit : 17'h1ffff;

   always_ff @(posedge clock) begin
      if (cmd.grad) begin
         a_ff <= (gx_pos >= gx_neg) ? 10'(gx_pos - gx_neg) : 10'(gx_neg - gx_pos);
         b_ff <= (gy_pos >= gy_neg) ? 10'(gy_pos - gy_neg) : 10'(gy_neg - gy_pos);
         // Gx and Gy both positive, or both zero or negative.
         same_sign_ff <= (gx_pos > gx_neg) == (gy_pos > gy_neg);
         zero_x_ff    <= 1'b0;
      end
      if (cmd.square) begin
         a2_ff <= 20'(a_ff) * 20'(a_ff);
         b2_ff <= 20'(b_ff) * 20'(b_ff);
         s_ff  <= 22'(11'(a_ff) + 11'(b_ff)) * 22'(11'(a_ff) + 11'(b_ff));
      end
      if (cmd.root_init) begin
         rx_ff   <= 17'(root_x[15:0]);
         root_ff <= '0;
         big_ff  <= (root_x[20:16] != '0) || zero_x_ff;
         if (23'(s_ff) <= {2'b0, b2_ff, 1'b0}) begin
            dir_ff <= DIR_0;
         end else if (23'(s_ff) <= {2'b0, a2_ff, 1'b0}) begin
            dir_ff <= DIR_90;
         end else if (same_sign_ff) begin
            dir_ff <= DIR_45;
         end else begin
            dir_ff <= DIR_135;
         end
      end
      if (cmd.root_step) begin
         if (root_try != 17'h1ffff) begin
            rx_ff   <= rx_ff - root_try;
            root_ff <= (root_ff >> 1) + root_bit;
         end else begin
            root_ff <= root_ff >> 1;
         end
      end
   end

   // Result register, loaded as the item completes.
   logic [7:0] blurred_ff, magnitude_ff;
   logic [1:0] direction_ff;
   logic       last_ff;

   always_ff @(posedge clock) begin
      if (cmd.finish && out_active) begin
         blurred_ff   <= s_win_ff[1][1];
         magnitude_ff <= out_inside ? (big_ff ? 8'd255 : root_ff[7:0]) : 8'd0;
         direction_ff <= out_inside ? dir_ff : DIR_0;
         last_ff      <= out_last;
      end
   end

   assign blurred   = blurred_ff;
   assign magnitude = magnitude_ff;
   assign direction = direction_ff;
   assign last      = last_ff;

endmodule

`default_nettype wire

>>> hw/rtl/gaussian_sobel_gradient_unit.sv
// Gaussian 5x5 blur and Sobel 3x3 gradient over a raster pixel stream.
// Each beat in is worked through (five-step blur accumulation, eight-step square
// root) before the next is taken; a finished result waiting for rsp_tready holds it.
// A result beat is offered once the beat that completes it has been worked through,
// which is 3*width+3 beats after its own pixel.
// Synchronous active-high reset: counters cleared, width and height set to 512;
// the line buffers are not cleared. A register write restarts the frame.
`default_nettype none

module gaussian_sobel_gradient_unit import gsg_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [7:0]            req_tdata,  // pixel[7:0]
   input  wire logic [0:0]            req_tuser,  // mode[0]
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [23:0]           rsp_tdata,  // blurred[7:0], magnitude[15:8],
                                                  // direction[17:16], zeros above
   output      logic                  rsp_tlast,
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [0:0]            csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   gsg_cmd_type    cmd;
   gsg_status_type status;
   logic [7:0]     blurred, magnitude;
   logic [1:0]     direction;

   assign csr_ready = 1'b1;

   gsg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   gsg_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .mode      (req_tuser[0]),
      .pixel     (req_tdata),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .blurred   (blurred),
      .magnitude (magnitude),
      .direction (direction),
      .last      (rsp_tlast)
   );

   assign rsp_tdata = {6'b0, direction, magnitude, blurred};

endmodule

`default_nettype wire

>>> hw/rtl/gsg_checker.sv
// Port-level checks for the gradient unit, bound to the top level.
// Uses gsg_pkg for the configuration data width.
`default_nettype none

module gsg_checker import gsg_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic [7:0]            req_tdata,
   input wire logic [0:0]            req_tuser,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [23:0]           rsp_tdata,
   input wire logic                  rsp_tlast,
   input wire logic                  csr_valid,
   input wire logic                  csr_ready,
   input wire logic [0:0]            csr_index,
   input wire logic [CSR_DATA_W-1:0] csr_data
);

   // A result that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   // The unit works on one beat at a time.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while busy");

   // A direction other than zero needs a non-zero gradient.
   a_dir_mag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[17:16] != DIR_0 |-> rsp_tdata[15:8] != 8'd0)
      else $error("direction set with zero magnitude");

   // Padding above the direction field is always zero.
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:18] == 6'd0)
      else $error("result padding not zero");

endmodule

bind gaussian_sobel_gradient_unit gsg_checker u_gsg_checker (.*);

`default_nettype wire
